// ----- rtl/sps_pkg.sv -----
// Shared types, codes and phase-ring helpers for the stepper phase sequencer.
`default_nettype none
package sps_pkg;

   localparam int TIMER_BITS  = 20;
   localparam int PERIOD_BITS = 20;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(2000);
   localparam logic [TIMER_BITS-1:0]  TIMER_MAX    = {TIMER_BITS{1'b1}};
   localparam logic [2:0] RING_MASK = 3'h7;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_STEP = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   localparam logic [1:0] MODE_WAVE = 2'd0;
   localparam logic [1:0] MODE_HALF = 2'd1;

   localparam logic [1:0] DIR_NONE = 2'b00;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EARLY = 2'd1;
   localparam logic [1:0] STATUS_BUSY  = 2'd2;

   typedef struct packed {
      logic [3:0] windings;
      logic [2:0] phase;
      logic       powered;
      logic [1:0] status;
   } rsp_type;

   // coil drive for each ring position: A, AB, B, BC, C, CD, D, DA
   function automatic logic [3:0] coil_of_phase(input logic [2:0] p);
      logic [3:0] c;
      case (p)
         3'd0: c = 4'h1;
         3'd1: c = 4'h3;
         3'd2: c = 4'h2;
         3'd3: c = 4'h6;
         3'd4: c = 4'h4;
         3'd5: c = 4'hC;
         3'd6: c = 4'h8;
         3'd7: c = 4'h9;
         default: c = 4'h0;
      endcase
      return c;
   endfunction

   // wave lands on even positions, full on odd ones, half moves by one
   function automatic logic [2:0] next_phase(input logic [2:0] p, input logic [1:0] mode,
                                             input logic fwd);
      logic [2:0] step;
      logic [2:0] n;
      if (mode == MODE_WAVE) begin
         step = 3'd2 - {2'b00, p[0]};
      end else if (mode == MODE_HALF) begin
         step = 3'd1;
      end else begin
         step = 3'd1 + {2'b00, p[0]};
      end
      n = fwd ? (p + step) : (p - step);
      return n & RING_MASK;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/stepper_phase_sequencer.sv -----
// Stepper phase sequencer: phase ring, step timer, pending command and result buffer.
// Results are registered: each reaches the rsp_ ports through the output register or the skid entry.
// Throughput: one item per cycle while req_ready is high; state updates in the cycle of the transfer.
// A two-entry result buffer (output register plus skid) lets items keep coming while a
// result waits; req_ready drops only while both entries are full.
// Reset (sync, active high): phase A, coils off, timer, pending, buffer clear, period 2000.
`default_nettype none
module stepper_phase_sequencer
   import sps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [PERIOD_BITS-1:0] csr_wr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [1:0]             req_step_mode,
   input  wire logic signed [1:0]      req_direction,
   input  wire logic                   req_wait_req,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [3:0]                  rsp_windings,
   output logic [2:0]                  rsp_phase,
   output logic                        rsp_powered,
   output logic [1:0]                  rsp_status
);

   logic [PERIOD_BITS-1:0] min_period_ff;
   logic [2:0]             phase_ff, phase_in;
   logic                   power_ff, power_in;
   logic [TIMER_BITS-1:0]  elapsed_ff, elapsed_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [1:0]             pend_mode_ff, pend_mode_in;
   logic [1:0]             pend_dir_ff, pend_dir_in;

   rsp_type head_ff, head_in, skid_ff, skid_in;
   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic                  accept;
   logic                  pop;
   logic                  res_valid;
   logic [1:0]            res_status;
   rsp_type               res;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic                  period_met;
   logic                  app_en;
   logic [1:0]            app_mode;
   logic [1:0]            app_dir;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = head_valid_ff && rsp_ready;

   assign elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff : elapsed_ff + TIMER_BITS'(1);
   assign period_met  = ({{(32-TIMER_BITS){1'b0}}, elapsed_ff} >=
                         {{(32-PERIOD_BITS){1'b0}}, min_period_ff});

   // command decode and state update
   always_comb begin
      phase_in      = phase_ff;
      power_in      = power_ff;
      elapsed_in    = elapsed_ff;
      pend_valid_in = pend_valid_ff;
      pend_mode_in  = pend_mode_ff;
      pend_dir_in   = pend_dir_ff;
      res_valid     = 1'b0;
      res_status    = STATUS_DONE;
      app_en        = 1'b0;
      app_mode      = req_step_mode;
      app_dir       = req_direction;
      if (accept) begin
         case (req_cmd)
            CMD_TICK: begin
               elapsed_in = elapsed_inc;
               if (pend_valid_ff && ({{(32-TIMER_BITS){1'b0}}, elapsed_inc} >=
                                     {{(32-PERIOD_BITS){1'b0}}, min_period_ff})) begin
                  pend_valid_in = 1'b0;
                  app_en        = 1'b1;
                  app_mode      = pend_mode_ff;
                  app_dir       = pend_dir_ff;
                  res_valid     = 1'b1;
               end
            end
            CMD_STEP: begin
               if (pend_valid_ff) begin
                  res_valid  = 1'b1;
                  res_status = STATUS_BUSY;
               end else if (req_direction == DIR_NONE && power_ff) begin
                  res_valid = 1'b1;
               end else if (period_met) begin
                  app_en    = 1'b1;
                  res_valid = 1'b1;
               end else if (req_wait_req) begin
                  pend_valid_in = 1'b1;
                  pend_mode_in  = req_step_mode;
                  pend_dir_in   = req_direction;
               end else begin
                  res_valid  = 1'b1;
                  res_status = STATUS_EARLY;
               end
            end
            CMD_OFF: begin
               res_valid = 1'b1;
               if (pend_valid_ff) begin
                  res_status = STATUS_BUSY;
               end else begin
                  power_in   = 1'b0;
                  elapsed_in = '0;
               end
            end
            default: begin
               // unused command: drop
            end
         endcase
         if (app_en) begin
            if (app_dir == DIR_NONE) begin
               if (!power_ff) begin
                  power_in   = 1'b1;
                  elapsed_in = '0;
               end
            end else begin
               phase_in   = next_phase(phase_ff, app_mode, !app_dir[1]);
               power_in   = 1'b1;
               elapsed_in = '0;
            end
         end
      end
      res.windings = power_in ? coil_of_phase(phase_in) : 4'h0;
      res.phase    = phase_in;
      res.powered  = power_in;
      res.status   = res_status;
   end

   // result buffer: head register with one skid entry behind it
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (res_valid) begin
            head_in = res;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!head_valid_ff) begin
            head_in       = res;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= PERIOD_RESET;
         phase_ff      <= '0;
         power_ff      <= 1'b0;
         elapsed_ff    <= '0;
         pend_valid_ff <= 1'b0;
         pend_mode_ff  <= '0;
         pend_dir_ff   <= '0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_period_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         power_ff      <= power_in;
         elapsed_ff    <= elapsed_in;
         pend_valid_ff <= pend_valid_in;
         pend_mode_ff  <= pend_mode_in;
         pend_dir_ff   <= pend_dir_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid    = head_valid_ff;
   assign rsp_windings = head_ff.windings;
   assign rsp_phase    = head_ff.phase;
   assign rsp_powered  = head_ff.powered;
   assign rsp_status   = head_ff.status;

`ifndef SYNTHESIS
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held with empty output register");

   a_pending_power_on_unpowered: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_dir_ff == DIR_NONE) |-> !power_ff)
      else $error("pending power-on held while coils are on");

   a_off_clears_power: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_OFF && !pend_valid_ff) |=> !power_ff)
      else $error("power off did not clear the coils");

   a_unpowered_windings_zero: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && !head_ff.powered) |-> (head_ff.windings == 4'h0))
      else $error("windings driven while unpowered");

   a_busy_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && pend_valid_ff && (req_cmd == CMD_STEP || req_cmd == CMD_OFF))
      |=> ($stable(phase_ff) && $stable(power_ff) && pend_valid_ff))
      else $error("busy command changed the sequencer state");
`endif

endmodule
`default_nettype wire

// ----- tb/stepper_phase_sequencer_test.sv -----
// Self-checking testbench for the stepper phase sequencer: driver, monitor, predictor.
`timescale 1ns / 1ps
module stepper_phase_sequencer_test
   import sps_pkg::*;
();

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [1:0] MODE_FULL    = 2'd2;
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam logic [1:0] DIR_FWD      = 2'b01;
   localparam logic [1:0] DIR_BACK     = 2'b11;
   localparam logic [1:0] DIR_BACK_ALT = 2'b10;
   localparam logic [PERIOD_BITS-1:0] PERIOD_TOP = {PERIOD_BITS{1'b1}};
   localparam int LONG_HOLD   = 150;
   // longest quiet stretch in a good run is the long hold plus a phase change
   localparam int QUIET_LIMIT = 4000;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] step_mode;
      logic [1:0] direction;
      logic       wait_req;
   } step_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [PERIOD_BITS-1:0] csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_cmd = CMD_TICK;
   logic [1:0]             req_step_mode = MODE_WAVE;
   logic [1:0]             req_direction = DIR_NONE;
   logic                   req_wait_req = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [3:0]             rsp_windings;
   logic [2:0]             rsp_phase;
   logic                   rsp_powered;
   logic [1:0]             rsp_status;

   stepper_phase_sequencer dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_step_mode (req_step_mode),
      .req_direction (req_direction),
      .req_wait_req  (req_wait_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_windings  (rsp_windings),
      .rsp_phase     (rsp_phase),
      .rsp_powered   (rsp_powered),
      .rsp_status    (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // motor state as the block should hold it
   logic [2:0]             ring_pos = 3'd0;
   logic                   coils_on = 1'b0;
   logic [TIMER_BITS-1:0]  tick_count = '0;
   logic                   held_valid = 1'b0;
   logic [1:0]             held_mode = MODE_WAVE;
   logic [1:0]             held_dir = DIR_NONE;
   logic [PERIOD_BITS-1:0] period_limit = PERIOD_RESET;

   step_item_type cmd_backlog[$];
   rsp_type       due_results[$];
   step_item_type cur_item;
   rsp_type       want_rsp;

   int  items_offered = 0;
   int  items_taken = 0;
   int  results_checked = 0;
   int  early_seen = 0;
   int  busy_seen = 0;
   int  period_writes = 0;
   int  error_count = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   bit  calm = 1'b0;
   bit  long_hold_go = 1'b0;

   function automatic logic [2:0] ring_advance(input logic [2:0] pos, input logic [1:0] mode,
                                               input logic fwd);
      logic [2:0] nxt;
      case (mode)
         MODE_WAVE: nxt = fwd ? ((pos | 3'd1) + 3'd1) : ((pos - 3'd1) & 3'b110);
         MODE_HALF: nxt = fwd ? (pos + 3'd1) : (pos - 3'd1);
         default:   nxt = fwd ? ((pos + 3'd1) | 3'd1) : ((pos - 3'd2) | 3'd1);
      endcase
      return nxt;
   endfunction

   // even positions drive one coil, odd positions the coil pair around them
   function automatic logic [3:0] coil_drive(input logic [2:0] pos);
      logic [3:0] one;
      one = 4'b0001 << pos[2:1];
      return pos[0] ? (one | {one[2:0], one[3]}) : one;
   endfunction

   task automatic carry_out(input logic [1:0] mode, input logic [1:0] dir);
      if (dir == DIR_NONE) begin
         if (!coils_on) begin
            coils_on = 1'b1;
            tick_count = '0;
         end
      end else begin
         ring_pos = ring_advance(ring_pos, mode, !dir[1]);
         coils_on = 1'b1;
         tick_count = '0;
      end
   endtask

   task automatic step_motor(input step_item_type it);
      logic       has_result;
      logic [1:0] verdict;
      rsp_type    r;
      has_result = 1'b0;
      verdict = STATUS_DONE;
      case (it.cmd)
         CMD_TICK: begin
            if (tick_count != TIMER_MAX) tick_count = tick_count + TIMER_BITS'(1);
            if (held_valid && tick_count >= period_limit) begin
               held_valid = 1'b0;
               carry_out(held_mode, held_dir);
               has_result = 1'b1;
            end
         end
         CMD_STEP, CMD_OFF: begin
            has_result = 1'b1;
            if (held_valid) begin
               verdict = STATUS_BUSY;
            end else if (it.cmd == CMD_OFF) begin
               coils_on = 1'b0;
               tick_count = '0;
            end else if (it.direction == DIR_NONE && coils_on) begin
               verdict = STATUS_DONE;
            end else if (tick_count >= period_limit) begin
               carry_out(it.step_mode, it.direction);
            end else if (it.wait_req) begin
               held_valid = 1'b1;
               held_mode = it.step_mode;
               held_dir = it.direction;
               has_result = 1'b0;
            end else begin
               verdict = STATUS_EARLY;
            end
         end
         default: ;
      endcase
      if (has_result) begin
         r.windings = coils_on ? coil_drive(ring_pos) : 4'h0;
         r.phase = ring_pos;
         r.powered = coils_on;
         r.status = verdict;
         due_results.push_back(r);
      end
   endtask

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // driver: one transfer per accepted item, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            step_motor(cur_item);
            items_taken++;
         end
         if (req_valid && !req_ready) begin
            // hold the item until it transfers
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(99) < gap_pct) begin
            gap_left = $urandom_range(18, 0);
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            cur_item = cmd_backlog.pop_front();
            items_offered++;
            req_cmd <= cur_item.cmd;
            req_step_mode <= cur_item.step_mode;
            req_direction <= cur_item.direction;
            req_wait_req <= cur_item.wait_req;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each result transfer, stall the result side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (due_results.size() == 0) begin
               report_error($sformatf("result w=%h p=%0d on=%b st=%0d with nothing expected",
                                      rsp_windings, rsp_phase, rsp_powered, rsp_status));
            end else begin
               want_rsp = due_results.pop_front();
               if (want_rsp.status == STATUS_EARLY) early_seen++;
               if (want_rsp.status == STATUS_BUSY) busy_seen++;
               if (rsp_windings !== want_rsp.windings || rsp_phase !== want_rsp.phase ||
                   rsp_powered !== want_rsp.powered || rsp_status !== want_rsp.status)
                  report_error($sformatf({"result %0d: got w=%h p=%0d on=%b st=%0d, ",
                                          "want w=%h p=%0d on=%b st=%0d"},
                                         results_checked, rsp_windings, rsp_phase, rsp_powered,
                                         rsp_status, want_rsp.windings, want_rsp.phase,
                                         want_rsp.powered, want_rsp.status));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_go) begin
            long_hold_go = 1'b0;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < stall_pct) begin
            hold_left = $urandom_range(18, 0);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d items outstanding, %0d results due",
                     cmd_backlog.size() + items_offered - items_taken, due_results.size());
            $display("stepper_phase_sequencer_test: errors");
            $finish;
         end
      end
   end

   function automatic void queue_item(input logic [1:0] cmd, input logic [1:0] mode,
                                      input logic [1:0] dir, input logic hold);
      step_item_type it;
      it.cmd = cmd;
      it.step_mode = mode;
      it.direction = dir;
      it.wait_req = hold;
      cmd_backlog.push_back(it);
   endfunction

   function automatic void queue_ticks(input int count);
      for (int i = 0; i < count; i++)
         queue_item(CMD_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)),
                    1'($urandom_range(1)));
   endfunction

   function automatic step_item_type random_item(input int step_pct);
      step_item_type it;
      int unsigned   roll;
      roll = $urandom_range(99);
      it.step_mode = 2'($urandom_range(3));
      it.direction = 2'($urandom_range(3));
      it.wait_req = 1'($urandom_range(1));
      if (roll < step_pct) it.cmd = CMD_STEP;
      else if (roll < step_pct + 8) it.cmd = CMD_OFF;
      else if (roll < step_pct + 10) it.cmd = CMD_UNUSED;
      else it.cmd = CMD_TICK;
      return it;
   endfunction

   // wait until every item has transferred and every result has come back
   task automatic settle();
      while (cmd_backlog.size() != 0 || items_taken != items_offered || due_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      period_limit = value;
      period_writes++;
   endtask

   initial begin
      int unsigned period_set[5];
      int          issued;
      int          run;
      period_set = '{0, 1, 4, 13, 37};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset period: early rejects, a held command and busy replies behind it
      queue_item(CMD_STEP, MODE_HALF, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_WAVE, DIR_NONE, 1'b0);
      queue_item(CMD_UNUSED, MODE_SPARE, DIR_BACK, 1'b1);
      queue_item(CMD_OFF, MODE_WAVE, DIR_NONE, 1'b0);
      queue_ticks(40);
      queue_item(CMD_STEP, MODE_WAVE, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_HALF, DIR_FWD, 1'b1);
      queue_item(CMD_STEP, MODE_FULL, DIR_BACK, 1'b0);
      queue_item(CMD_OFF, MODE_WAVE, DIR_NONE, 1'b1);
      queue_ticks(5);
      settle();

      // no period: the held command completes, then every mode and direction
      write_period('0);
      queue_ticks(1);
      queue_item(CMD_OFF, MODE_HALF, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_SPARE, DIR_NONE, 1'b0);
      queue_item(CMD_STEP, MODE_WAVE, DIR_NONE, 1'b1);
      queue_item(CMD_STEP, MODE_WAVE, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_WAVE, DIR_BACK, 1'b0);
      queue_item(CMD_STEP, MODE_HALF, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_WAVE, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_HALF, DIR_BACK_ALT, 1'b0);
      queue_item(CMD_STEP, MODE_WAVE, DIR_BACK, 1'b0);
      queue_item(CMD_STEP, MODE_FULL, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_FULL, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_FULL, DIR_BACK, 1'b0);
      queue_item(CMD_STEP, MODE_SPARE, DIR_FWD, 1'b1);
      queue_item(CMD_STEP, MODE_SPARE, DIR_BACK_ALT, 1'b0);
      queue_item(CMD_UNUSED, MODE_HALF, DIR_FWD, 1'b0);
      queue_item(CMD_OFF, MODE_SPARE, DIR_BACK, 1'b1);
      queue_item(CMD_STEP, MODE_HALF, DIR_BACK, 1'b0);
      settle();

      // short period: pending commands, busy replies, power-on held until due
      write_period(PERIOD_BITS'(3));
      queue_item(CMD_STEP, MODE_FULL, DIR_FWD, 1'b1);
      queue_ticks(1);
      queue_item(CMD_STEP, MODE_WAVE, DIR_BACK, 1'b0);
      queue_item(CMD_OFF, MODE_WAVE, DIR_NONE, 1'b0);
      queue_ticks(2);
      queue_item(CMD_STEP, MODE_HALF, DIR_FWD, 1'b0);
      queue_item(CMD_OFF, MODE_WAVE, DIR_NONE, 1'b0);
      queue_item(CMD_STEP, MODE_HALF, DIR_NONE, 1'b1);
      queue_ticks(3);
      settle();

      // random phases over several periods; the first one also stalls results for long
      for (int ph = 0; ph < 5; ph++) begin
         write_period(PERIOD_BITS'(period_set[ph]));
         case (ph)
            0: begin gap_pct = 10; stall_pct = 20; long_hold_go = 1'b1; end
            1: begin gap_pct = 0;  stall_pct = 0;  end
            2: begin gap_pct = 15; stall_pct = 15; end
            3: begin gap_pct = 25; stall_pct = 10; end
            default: begin gap_pct = 5; stall_pct = 30; end
         endcase
         issued = 0;
         while (issued < 130) begin
            if (period_set[ph] > 1 && $urandom_range(9) == 0) begin
               run = $urandom_range(2 * period_set[ph], 1);
               queue_ticks(run);
               issued += run;
            end else begin
               cmd_backlog.push_back(random_item(ph == 0 ? 80 : 35));
               issued++;
            end
         end
         // let any held command complete before the next setting
         queue_ticks(period_set[ph] + 2);
         settle();
      end

      // no idling to the end: widest period is not met, then back-to-back random items
      calm = 1'b1;
      write_period(PERIOD_TOP);
      queue_item(CMD_OFF, MODE_WAVE, DIR_NONE, 1'b0);
      queue_ticks(20);
      queue_item(CMD_STEP, MODE_HALF, DIR_FWD, 1'b0);
      queue_item(CMD_STEP, MODE_WAVE, DIR_NONE, 1'b0);
      settle();
      write_period(PERIOD_BITS'(2));
      for (int i = 0; i < 50; i++)
         cmd_backlog.push_back(random_item(35));
      queue_ticks(4);
      settle();

      $display("ran %0d items through %0d period settings, checked %0d results",
               items_taken, period_writes + 1, results_checked);
      $display("results seen: %0d rejected as early, %0d busy", early_seen, busy_seen);
      if (error_count == 0)
         $display("stepper_phase_sequencer_test: clean");
      else
         $display("stepper_phase_sequencer_test: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sps_pkg.sv
rtl/stepper_phase_sequencer.sv
tb/stepper_phase_sequencer_test.sv
